### src/generational_slot_allocator_top_defines.svh
// Assertion macros shared by the checker of the generational slot allocator.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/gsa_pkg.sv
// Types and constants shared by the generational slot allocator modules.
`default_nettype none

package gsa_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int GEN_W          = 16;
    localparam int HANDLE_W       = 32;
    localparam int OPCODE_W       = 3;
    localparam int COUNT_W        = 5;
    localparam int COUNT_MAX      = 31;
    localparam int TDATA_IN_W     = 40;
    localparam int TDATA_OUT_W    = 40;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC     = 3'd0,
        OP_ALLOC_MGD = 3'd1,
        OP_CHECK     = 3'd2,
        OP_REMOVE    = 3'd3,
        OP_CLEAR     = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [GEN_W-1:0] gen;
        logic             used;
        logic             managed;
    } t_slot;

    typedef struct packed {
        logic [COUNT_W-1:0]  live_count;
        logic                ok;
        logic [HANDLE_W-1:0] handle_out;
    } t_result;

endpackage

`default_nettype wire

### src/gsa_slot_ram.sv
// Slot table memory with one write port and one registered read port.
`default_nettype none

module gsa_slot_ram #(
    parameter int DEPTH = gsa_pkg::SLOT_COUNT_DEF,
    parameter int AW    = 4,
    parameter int DW    = $bits(gsa_pkg::t_slot)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/gsa_ctrl.sv
// Sequencer walking the slot table one entry per cycle on alloc or clear.
`default_nettype none

module gsa_ctrl #(
    parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF,
    parameter int AW         = 4,
    parameter int DW         = $bits(gsa_pkg::t_slot)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [gsa_pkg::OPCODE_W-1:0]    i_opcode,
    input  wire logic [gsa_pkg::HANDLE_W-1:0]    i_handle,
    output logic                                 o_idle,
    input  wire logic                            i_res_free,
    output logic                                 o_done,
    output gsa_pkg::t_result                     o_result,
    output logic                                 o_we,
    output logic      [AW-1:0]                   o_waddr,
    output logic      [DW-1:0]                   o_wdata,
    output logic                                 o_re,
    output logic      [AW-1:0]                   o_raddr,
    input  wire logic [DW-1:0]                   i_rdata
);

    localparam int LW = $clog2(SLOT_COUNT + 1);
    localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);

    gsa_pkg::t_state                    r_state, n_state;
    gsa_pkg::t_op                       r_op, n_op;
    logic [gsa_pkg::GEN_W-1:0]          r_gen, n_gen;
    logic [AW-1:0]                      r_addr, n_addr;
    logic                               r_more, n_more;
    logic                               r_rd_vld;
    logic [AW-1:0]                      r_rd_idx;
    logic [gsa_pkg::HANDLE_W-1:0]       r_handle_out, n_handle_out;
    logic                               r_ok, n_ok;
    logic [LW-1:0]                      r_live, n_live;

    gsa_pkg::t_slot                     rd;
    gsa_pkg::t_slot                     wr;
    logic [gsa_pkg::GEN_W-1:0]          gen_inc;
    logic [gsa_pkg::GEN_W-1:0]          low;
    logic                               scan_op;
    logic                               hit;

    assign rd      = gsa_pkg::t_slot'(i_rdata);
    assign gen_inc = (rd.gen == 16'hFFFF) ? 16'd1 : rd.gen + 16'd1;
    assign low     = i_handle[gsa_pkg::GEN_W-1:0];
    assign scan_op = (r_op == gsa_pkg::OP_ALLOC) || (r_op == gsa_pkg::OP_ALLOC_MGD)
                     || (r_op == gsa_pkg::OP_CLEAR);
    assign hit     = rd.used && (rd.gen == r_gen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gsa_pkg::ST_INIT;
            r_op     <= gsa_pkg::OP_ALLOC;
            r_addr   <= '0;
            r_more   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_live   <= '0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_addr   <= n_addr;
            r_more   <= n_more;
            r_rd_vld <= o_re;
            r_live   <= n_live;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gen        <= n_gen;
        r_rd_idx     <= r_addr;
        r_handle_out <= n_handle_out;
        r_ok         <= n_ok;
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_gen        = r_gen;
        n_addr       = r_addr;
        n_more       = r_more;
        n_handle_out = r_handle_out;
        n_ok         = r_ok;
        n_live       = r_live;
        o_we         = 1'b0;
        o_re         = 1'b0;
        o_done       = 1'b0;
        wr           = rd;
        unique case (r_state)
            gsa_pkg::ST_INIT: begin
                o_we   = 1'b1;
                wr     = '0;
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST) begin
                    n_state = gsa_pkg::ST_IDLE;
                    n_addr  = '0;
                end
            end
            gsa_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_gen        = i_handle[gsa_pkg::HANDLE_W-1:gsa_pkg::GEN_W];
                    n_handle_out = '0;
                    n_ok         = 1'b0;
                    n_more       = 1'b1;
                    n_addr       = '0;
                    n_state      = gsa_pkg::ST_RESP;
                    case (i_opcode) inside
                        gsa_pkg::OP_ALLOC, gsa_pkg::OP_ALLOC_MGD, gsa_pkg::OP_CLEAR: begin
                            n_op    = gsa_pkg::t_op'(i_opcode);
                            n_state = gsa_pkg::ST_SCAN;
                        end
                        gsa_pkg::OP_CHECK, gsa_pkg::OP_REMOVE: begin
                            n_op = gsa_pkg::t_op'(i_opcode);
                            if (low != 16'd0 && low <= 16'(SLOT_COUNT)) begin
                                n_addr  = AW'(low - 16'd1);
                                n_state = gsa_pkg::ST_SCAN;
                            end
                        end
                        default: begin
                            n_more = 1'b0;
                        end
                    endcase
                end
            end
            gsa_pkg::ST_SCAN: begin
                o_re = r_more;
                if (r_more) begin
                    n_addr = r_addr + 1'b1;
                    n_more = scan_op && (r_addr != LAST);
                end
                if (r_rd_vld) begin
                    unique case (r_op)
                        gsa_pkg::OP_ALLOC, gsa_pkg::OP_ALLOC_MGD: begin
                            if (!rd.used) begin
                                o_we         = 1'b1;
                                wr.gen       = gen_inc;
                                wr.used      = 1'b1;
                                wr.managed   = (r_op == gsa_pkg::OP_ALLOC_MGD);
                                n_handle_out = {gen_inc, 16'(r_rd_idx) + 16'd1};
                                n_ok         = 1'b1;
                                n_live       = r_live + 1'b1;
                                n_state      = gsa_pkg::ST_RESP;
                            end else if (r_rd_idx == LAST) begin
                                n_state = gsa_pkg::ST_RESP;
                            end
                        end
                        gsa_pkg::OP_CLEAR: begin
                            o_we    = 1'b1;
                            wr.used = 1'b0;
                            if (r_rd_idx == LAST) begin
                                n_ok    = 1'b1;
                                n_live  = '0;
                                n_state = gsa_pkg::ST_RESP;
                            end
                        end
                        gsa_pkg::OP_CHECK: begin
                            n_ok    = hit && rd.managed;
                            n_state = gsa_pkg::ST_RESP;
                        end
                        gsa_pkg::OP_REMOVE: begin
                            if (hit) begin
                                o_we    = 1'b1;
                                wr.used = 1'b0;
                                n_ok    = 1'b1;
                                n_live  = r_live - 1'b1;
                            end
                            n_state = gsa_pkg::ST_RESP;
                        end
                        default: begin
                            n_state = gsa_pkg::ST_RESP;
                        end
                    endcase
                end
            end
            gsa_pkg::ST_RESP: begin
                o_done = i_res_free;
                if (i_res_free) begin
                    n_state = gsa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gsa_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_idle  = (r_state == gsa_pkg::ST_IDLE);
    assign o_waddr = (r_state == gsa_pkg::ST_INIT) ? r_addr : r_rd_idx;
    assign o_wdata = DW'(wr);
    assign o_raddr = r_addr;

    assign o_result.handle_out = r_handle_out;
    assign o_result.ok         = r_ok;
    assign o_result.live_count = (32'(r_live) > 32'(gsa_pkg::COUNT_MAX))
                                 ? gsa_pkg::COUNT_W'(gsa_pkg::COUNT_MAX)
                                 : gsa_pkg::COUNT_W'(r_live);

endmodule

`default_nettype wire

### src/generational_slot_allocator_top.sv
// Top level of the generational slot allocator with its stream ports.
//
// One request on the slave stream carries an opcode and a handle; every
// request gives exactly one result on the master stream with the new
// handle, a success flag and the count of slots in use afterwards.
// Requests are taken one at a time: tready is high only while the
// sequencer is idle, and drops for the whole operation.
// Allocation and clear all walk the slot table at one entry per cycle
// through a single memory read port: an allocation stops at the first
// free slot, while a full table or a clear all reads every entry. Check
// and remove read one entry; a malformed handle or an unknown opcode
// reads none and goes straight to the result.
// After reset the slot table is cleared one entry per cycle; tready stays
// low until every entry is cleared. The result sits in an output register;
// when the receiver stalls, it holds there and the next request may still
// be accepted and worked on until its result is ready to be written.
`default_nettype none

module generational_slot_allocator_top #(
    parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // Fields from bit 0: opcode[2:0], handle_in[34:3], zero fill[39:35].
    input  wire logic [gsa_pkg::TDATA_IN_W-1:0]     i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // Fields from bit 0: handle_out[31:0], ok[32], live_count[37:33], zero fill[39:38].
    output logic      [gsa_pkg::TDATA_OUT_W-1:0]    o_m_axis_tdata
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int DW = $bits(gsa_pkg::t_slot);

    logic                       idle;
    logic                       start;
    logic                       done;
    logic                       res_free;
    gsa_pkg::t_result           result;
    logic                       we;
    logic [AW-1:0]              waddr;
    logic [DW-1:0]              wdata;
    logic                       re;
    logic [AW-1:0]              raddr;
    logic [DW-1:0]              rdata;
    logic                       r_m_tvalid;
    logic [gsa_pkg::TDATA_OUT_W-1:0] r_m_tdata;

    assign start    = i_s_axis_tvalid && idle;
    assign res_free = !r_m_tvalid || i_m_axis_tready;

    gsa_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .AW         (AW),
        .DW         (DW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_opcode   (i_s_axis_tdata[gsa_pkg::OPCODE_W-1:0]),
        .i_handle   (i_s_axis_tdata[gsa_pkg::OPCODE_W +: gsa_pkg::HANDLE_W]),
        .o_idle     (idle),
        .i_res_free (res_free),
        .o_done     (done),
        .o_result   (result),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

    gsa_slot_ram #(
        .DEPTH (SLOT_COUNT),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (done) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_m_tdata <= gsa_pkg::TDATA_OUT_W'(result);
        end
    end

    assign o_s_axis_tready = idle;
    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;

endmodule

`default_nettype wire

### src/gsa_checker.sv
// Port-level checker for the generational slot allocator and its bind.
`default_nettype none
`include "generational_slot_allocator_top_defines.svh"

module gsa_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_axis_tvalid,
    input wire logic                            o_s_axis_tready,
    input wire logic [gsa_pkg::TDATA_IN_W-1:0]  i_s_axis_tdata,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [gsa_pkg::TDATA_OUT_W-1:0] o_m_axis_tdata
);

    `GSA_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "Stalled result changed.")

    `GSA_ASSERT_NEXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "Ready stayed high after a request was taken.")

    `GSA_ASSERT_SAME(a_fail_no_handle, o_m_axis_tvalid && !o_m_axis_tdata[32], o_m_axis_tdata[31:0] == 32'd0, "Failed request returned a handle.")

    `GSA_ASSERT_SAME(a_handle_fields, o_m_axis_tvalid && (o_m_axis_tdata[31:0] != 32'd0), (o_m_axis_tdata[31:16] != 16'd0) && (o_m_axis_tdata[15:0] != 16'd0) && o_m_axis_tdata[32], "Handle has a zero generation or index.")

endmodule

bind generational_slot_allocator_top gsa_checker u_gsa_checker (.*);

`default_nettype wire

### bench/generational_slot_allocator_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench that streams slot requests into the allocator and scores every result.
module generational_slot_allocator_top_tb;

    localparam int SLOT_N       = gsa_pkg::SLOT_COUNT_DEF;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int PHASE_ITEMS  = 387;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_LIMIT = 10;
    localparam logic [gsa_pkg::OPCODE_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [gsa_pkg::OPCODE_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [gsa_pkg::OPCODE_W-1:0] OP_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [gsa_pkg::OPCODE_W-1:0] op;
        logic [gsa_pkg::HANDLE_W-1:0] handle;
        logic [4:0]                   reps;
        logic                         typed;
        gsa_pkg::t_result             want;
    } t_stim_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_axis_tvalid;
    logic                            o_s_axis_tready;
    logic [gsa_pkg::TDATA_IN_W-1:0]  i_s_axis_tdata;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready;
    logic [gsa_pkg::TDATA_OUT_W-1:0] o_m_axis_tdata;

    logic [gsa_pkg::GEN_W-1:0] slot_gen  [SLOT_N];
    logic                      slot_live [SLOT_N];
    logic                      slot_mgd  [SLOT_N];

    gsa_pkg::t_result pending_results[$];
    gsa_pkg::t_result want_r;
    gsa_pkg::t_result got_r;
    int      mismatch_count = 0;
    int      sender_idle_pct = 0;
    int      recv_idle_pct = 0;
    bit      hold_asked = 1'b0;
    int      hold_left = 0;

    generational_slot_allocator_top #(
        .SLOT_COUNT(SLOT_N)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int find_live_slot(logic [gsa_pkg::HANDLE_W-1:0] h);
        int low;
        int idx;
        low = int'(h[15:0]);
        idx = -1;
        if (h != '0 && low != 0 && low <= SLOT_N) begin
            if (slot_live[low-1] && slot_gen[low-1] == h[31:16]) begin
                idx = low - 1;
            end
        end
        return idx;
    endfunction

    function automatic gsa_pkg::t_result apply_slot_op(logic [gsa_pkg::OPCODE_W-1:0] op,
                                                       logic [gsa_pkg::HANDLE_W-1:0] h);
        gsa_pkg::t_result          r;
        int                        idx;
        int                        i;
        int                        used_n;
        logic [gsa_pkg::GEN_W-1:0] g;
        r = '0;
        idx = -1;
        case (op)
            gsa_pkg::OP_ALLOC, gsa_pkg::OP_ALLOC_MGD: begin
                for (i = 0; i < SLOT_N && idx < 0; i++) begin
                    if (!slot_live[i]) idx = i;
                end
                if (idx >= 0) begin
                    slot_live[idx] = 1'b1;
                    slot_mgd[idx] = (op == gsa_pkg::OP_ALLOC_MGD);
                    g = slot_gen[idx] + 1'b1;
                    if (g == '0) g = 16'd1;
                    slot_gen[idx] = g;
                    r.handle_out = {g, 16'(idx + 1)};
                    r.ok = 1'b1;
                end
            end
            gsa_pkg::OP_CHECK: begin
                idx = find_live_slot(h);
                if (idx >= 0 && slot_mgd[idx]) r.ok = 1'b1;
            end
            gsa_pkg::OP_REMOVE: begin
                idx = find_live_slot(h);
                if (idx >= 0) begin
                    slot_live[idx] = 1'b0;
                    r.ok = 1'b1;
                end
            end
            gsa_pkg::OP_CLEAR: begin
                for (i = 0; i < SLOT_N; i++) slot_live[i] = 1'b0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        used_n = 0;
        for (i = 0; i < SLOT_N; i++) begin
            if (slot_live[i]) used_n++;
        end
        r.live_count = gsa_pkg::COUNT_W'((used_n > gsa_pkg::COUNT_MAX) ? gsa_pkg::COUNT_MAX
                                                                        : used_n);
        return r;
    endfunction

    function automatic t_stim_row stim_row(logic [gsa_pkg::OPCODE_W-1:0] op,
                                           logic [gsa_pkg::HANDLE_W-1:0] h,
                                           int reps, logic typed,
                                           logic [gsa_pkg::HANDLE_W-1:0] hout,
                                           logic ok, int cnt);
        t_stim_row s;
        s.op = op;
        s.handle = h;
        s.reps = 5'(reps);
        s.typed = typed;
        s.want.handle_out = hout;
        s.want.ok = ok;
        s.want.live_count = gsa_pkg::COUNT_W'(cnt);
        return s;
    endfunction

    // Offers one request and, once it is taken, queues the result it must produce.
    task automatic send_request(input logic [gsa_pkg::OPCODE_W-1:0] op,
                                input logic [gsa_pkg::HANDLE_W-1:0] h,
                                input logic typed, input gsa_pkg::t_result want,
                                output gsa_pkg::t_result predicted);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'b0, h, op};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predicted = apply_slot_op(op, h);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic flag_field(input string what, input logic [gsa_pkg::HANDLE_W-1:0] exp_v,
                              input logic [gsa_pkg::HANDLE_W-1:0] act_v);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%s differs: expected 0x%08h, got 0x%08h", what, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_r = o_m_axis_tdata[$bits(gsa_pkg::t_result)-1:0];
            if (pending_results.size() == 0) begin
                flag_field("unexpected result handle_out", '0, got_r.handle_out);
            end else begin
                want_r = pending_results.pop_front();
                if (got_r.handle_out !== want_r.handle_out) begin
                    flag_field("handle_out", want_r.handle_out, got_r.handle_out);
                end
                if (got_r.ok !== want_r.ok) begin
                    flag_field("ok", 32'(want_r.ok), 32'(got_r.ok));
                end
                if (got_r.live_count !== want_r.live_count) begin
                    flag_field("live_count", 32'(want_r.live_count), 32'(got_r.live_count));
                end
            end
        end
    end

    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asked) begin
                hold_asked = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("generational_slot_allocator_top: mismatch");
        $finish;
    end

    initial begin
        t_stim_row                    rows [25];
        gsa_pkg::t_result             got;
        int                           phase;
        int                           n;
        int                           pick;
        int                           slot;
        logic [gsa_pkg::OPCODE_W-1:0] op;
        logic [gsa_pkg::HANDLE_W-1:0] h;

        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        for (n = 0; n < SLOT_N; n++) begin
            slot_gen[n] = '0;
            slot_live[n] = 1'b0;
            slot_mgd[n] = 1'b0;
        end
        sender_idle_pct = 19;
        recv_idle_pct = 64;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        rows = '{
            stim_row(gsa_pkg::OP_ALLOC,     32'h0000_0000, 1, 1, 32'h0001_0001, 1, 1),
            stim_row(gsa_pkg::OP_ALLOC_MGD, 32'h0000_0000, 1, 1, 32'h0001_0002, 1, 2),
            stim_row(gsa_pkg::OP_CHECK,     32'h0001_0002, 1, 1, 32'h0, 1, 2),
            stim_row(gsa_pkg::OP_CHECK,     32'h0001_0001, 1, 1, 32'h0, 0, 2),
            stim_row(gsa_pkg::OP_CHECK,     32'h0000_0000, 1, 1, 32'h0, 0, 2),
            stim_row(gsa_pkg::OP_CHECK,     32'h0001_0000, 1, 1, 32'h0, 0, 2),
            stim_row(gsa_pkg::OP_CHECK,     32'h0001_0011, 1, 1, 32'h0, 0, 2),
            stim_row(gsa_pkg::OP_CHECK,     32'hFFFF_FFFF, 1, 1, 32'h0, 0, 2),
            stim_row(gsa_pkg::OP_CHECK,     32'h0002_0002, 1, 1, 32'h0, 0, 2),
            stim_row(gsa_pkg::OP_CHECK,     32'h0000_0003, 1, 1, 32'h0, 0, 2),
            stim_row(gsa_pkg::OP_REMOVE,    32'h0002_0001, 1, 1, 32'h0, 0, 2),
            stim_row(gsa_pkg::OP_REMOVE,    32'h0001_0001, 1, 1, 32'h0, 1, 1),
            stim_row(gsa_pkg::OP_REMOVE,    32'h0001_0001, 1, 1, 32'h0, 0, 1),
            stim_row(OP_SPARE_LO,           32'h0001_0002, 1, 1, 32'h0, 0, 1),
            stim_row(OP_SPARE_HI,           32'hFFFF_FFFF, 1, 1, 32'h0, 0, 1),
            stim_row(gsa_pkg::OP_ALLOC,     32'hFFFF_FFFF, 1, 1, 32'h0002_0001, 1, 2),
            stim_row(gsa_pkg::OP_CLEAR,     32'h0001_0002, 1, 1, 32'h0, 1, 0),
            stim_row(gsa_pkg::OP_CHECK,     32'h0001_0002, 1, 1, 32'h0, 0, 0),
            stim_row(OP_SPARE_MID,          32'h0000_0000, 1, 1, 32'h0, 0, 0),
            stim_row(gsa_pkg::OP_REMOVE,    32'h0002_0001, 1, 1, 32'h0, 0, 0),
            stim_row(gsa_pkg::OP_ALLOC,     32'h0000_0000, 8, 0, 32'h0, 0, 0),
            stim_row(gsa_pkg::OP_ALLOC_MGD, 32'h0000_0000, 8, 0, 32'h0, 0, 0),
            stim_row(gsa_pkg::OP_ALLOC,     32'h0000_0000, 1, 1, 32'h0, 0, 16),
            stim_row(gsa_pkg::OP_ALLOC_MGD, 32'hFFFF_FFFF, 1, 1, 32'h0, 0, 16),
            stim_row(gsa_pkg::OP_CLEAR,     32'h0000_0000, 1, 1, 32'h0, 1, 0)
        };
        foreach (rows[r]) begin
            repeat (rows[r].reps) begin
                send_request(rows[r].op, rows[r].handle, rows[r].typed, rows[r].want, got);
            end
        end

        // The receiver stalls long enough for the input side to back up.
        hold_asked = 1'b1;
        for (phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 64 : 0;
            recv_idle_pct   = (phase == 0) ? 64 : (phase == 1) ? 19 : 0;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                slot = $urandom_range(SLOT_N - 1);
                h = {slot_gen[slot], 16'(slot + 1)};
                if (pick < 22) begin
                    op = gsa_pkg::OP_ALLOC;
                end else if (pick < 40) begin
                    op = gsa_pkg::OP_ALLOC_MGD;
                end else if (pick < 60) begin
                    op = gsa_pkg::OP_CHECK;
                end else if (pick < 78) begin
                    op = gsa_pkg::OP_REMOVE;
                end else if (pick < 81) begin
                    op = gsa_pkg::OP_CLEAR;
                end else if (pick < 88) begin
                    op = $urandom_range(1) ? gsa_pkg::OP_CHECK : gsa_pkg::OP_REMOVE;
                    h = h ^ (32'h1 << $urandom_range(31));
                end else if (pick < 95) begin
                    op = $urandom_range(1) ? gsa_pkg::OP_CHECK : gsa_pkg::OP_REMOVE;
                    h = $urandom;
                end else begin
                    op = gsa_pkg::OPCODE_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
                    h = $urandom;
                end
                send_request(op, h, 1'b0, '0, got);
            end
        end

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SLOT_N + 8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("generational_slot_allocator_top: match");
        end else begin
            $display("generational_slot_allocator_top: mismatch");
        end
        $finish;
    end

endmodule

### generational_slot_allocator_top.f
+incdir+src
src/gsa_pkg.sv
src/gsa_slot_ram.sv
src/gsa_ctrl.sv
src/generational_slot_allocator_top.sv
src/gsa_checker.sv
bench/generational_slot_allocator_top_tb.sv
